// ===== rtl/mcpc_pkg.sv =====
`timescale 1ns / 1ps

package mcpc_pkg;

    // Field widths fixed by the interface.
    localparam int DAY_W   = 9;
    localparam int COST_W  = 19;
    localparam int PRICE_W = 10;
    // Signed search limit: a day minus a pass length, from -30 up to 510.
    localparam int LIMIT_W = DAY_W + 2;

    typedef logic [DAY_W-1:0]          t_day;
    typedef logic [COST_W-1:0]         t_cost;
    typedef logic [PRICE_W-1:0]        t_price;
    typedef logic signed [LIMIT_W-1:0] t_limit;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_PRICE_ONE    = 2'd0;
    localparam logic [1:0] REG_PRICE_SEVEN  = 2'd1;
    localparam logic [1:0] REG_PRICE_THIRTY = 2'd2;

    // Pass lengths in days.
    localparam t_limit PASS_ONE    = t_limit'(1);
    localparam t_limit PASS_SEVEN  = t_limit'(7);
    localparam t_limit PASS_THIRTY = t_limit'(30);

    // Saturation ceiling of every cost.
    localparam t_cost COST_MAX = t_cost'(365000);

endpackage

// ===== rtl/min_cost_pass_cover.sv =====
`timescale 1ns / 1ps

// Minimum cost of 1-day, 7-day and 30-day travel passes, computed forward.
// Travel days enter on the input channel (i_in_valid / o_in_ready) in
// strictly increasing order; i_first starts a new plan and clears the kept
// history. Each input item yields exactly one result item on the output
// channel (o_out_valid / i_out_ready): the least total cost covering every
// day of the plan so far, saturated at 365000, or, for a day that is not
// above the previous one, the unchanged running cost with o_order_error set.
// From acceptance the item sits in the input register, then its search and
// update land in the result register, which drives o_out_valid. Throughput
// is one item per cycle while the receiver does not stall. The window of the
// last WINDOW_DEPTH days is compared in parallel, and the window shift
// happens in the same cycle that produces the result, so the following item
// sees it at once. When the receiver stalls, the result register holds its
// item, the input register takes one more item, and then o_in_ready drops
// until the result is taken. Reset (synchronous, active low) sets the prices
// to 2, 7 and 15, empties the window and zeroes the running and evicted costs.
// Prices are to be written through i_cfg_wr_en / i_cfg_addr / i_cfg_wdata
// only while the block is idle, which the block itself does not enforce;
// index 0 is the one-day price, 1 seven-day, 2 thirty-day.

module min_cost_pass_cover #(
    parameter int WINDOW_DEPTH = 30
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_wr_en,
    input  logic [1:0]             i_cfg_addr,
    input  mcpc_pkg::t_price       i_cfg_wdata,
    // input channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  mcpc_pkg::t_day         i_travel_day,
    input  logic                   i_first,
    // output channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output mcpc_pkg::t_cost        o_total_cost,
    output logic                   o_order_error
);
    import mcpc_pkg::*;

    // Price registers.
    t_price r_price_one;
    t_price r_price_seven;
    t_price r_price_thirty;

    // Input register.
    logic   r_in_vld;
    t_day   r_day;
    logic   r_first;

    // Result register.
    logic   r_out_vld;
    t_cost  r_out_cost;
    logic   r_out_err;

    // History: index 0 holds the newest day.
    t_day                    r_win_day  [WINDOW_DEPTH];
    t_cost                   r_win_cost [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] r_win_vld;
    t_cost                   r_evicted;
    t_cost                   r_running;

    logic                    w_proc;
    logic [WINDOW_DEPTH-1:0] w_vld_eff;
    t_cost                   w_evicted_eff;
    t_cost                   w_running_eff;
    logic                    w_err;
    t_limit                  w_day_s;
    t_cost                   w_best_one;
    t_cost                   w_best_seven;
    t_cost                   w_best_thirty;
    t_cost                   w_cand_one;
    t_cost                   w_cand_seven;
    t_cost                   w_cand_thirty;
    t_cost                   n_cost;
    logic                    n_err;

    // The item in the input register is worked on when the result register
    // is empty or is being emptied in this cycle.
    assign w_proc     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_proc;

    // A start flag sees an empty history.
    assign w_vld_eff     = r_first ? '0 : r_win_vld;
    assign w_evicted_eff = r_first ? '0 : r_evicted;
    assign w_running_eff = r_first ? '0 : r_running;

    assign w_err   = w_vld_eff[0] && (r_day <= r_win_day[0]);
    assign w_day_s = $signed({2'b00, r_day});

    mcpc_lookup #(.DEPTH(WINDOW_DEPTH)) u_look_one (
        .i_win_day  (r_win_day),
        .i_win_cost (r_win_cost),
        .i_win_vld  (w_vld_eff),
        .i_limit    (w_day_s - PASS_ONE),
        .i_fallback (w_evicted_eff),
        .o_cost     (w_best_one)
    );

    mcpc_lookup #(.DEPTH(WINDOW_DEPTH)) u_look_seven (
        .i_win_day  (r_win_day),
        .i_win_cost (r_win_cost),
        .i_win_vld  (w_vld_eff),
        .i_limit    (w_day_s - PASS_SEVEN),
        .i_fallback (w_evicted_eff),
        .o_cost     (w_best_seven)
    );

    mcpc_lookup #(.DEPTH(WINDOW_DEPTH)) u_look_thirty (
        .i_win_day  (r_win_day),
        .i_win_cost (r_win_cost),
        .i_win_vld  (w_vld_eff),
        .i_limit    (w_day_s - PASS_THIRTY),
        .i_fallback (w_evicted_eff),
        .o_cost     (w_best_thirty)
    );

    // Price plus earlier cost, clamped to the ceiling.
    function automatic t_cost sat_add(t_price price, t_cost cost);
        logic [COST_W:0] sum;
        sum = {1'b0, cost} + {{(COST_W + 1 - PRICE_W){1'b0}}, price};
        if (sum > {1'b0, COST_MAX}) begin
            return COST_MAX;
        end
        return sum[COST_W-1:0];
    endfunction

    assign w_cand_one    = sat_add(r_price_one, w_best_one);
    assign w_cand_seven  = sat_add(r_price_seven, w_best_seven);
    assign w_cand_thirty = sat_add(r_price_thirty, w_best_thirty);

    always_comb begin
        t_cost low;
        low = w_cand_one;
        if (w_cand_seven < low) begin
            low = w_cand_seven;
        end
        if (w_cand_thirty < low) begin
            low = w_cand_thirty;
        end
        if (w_err) begin
            n_cost = w_running_eff;
            n_err  = 1'b1;
        end else begin
            n_cost = low;
            n_err  = 1'b0;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_price_one    <= t_price'(2);
            r_price_seven  <= t_price'(7);
            r_price_thirty <= t_price'(15);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_PRICE_ONE:    r_price_one    <= i_cfg_wdata;
                REG_PRICE_SEVEN:  r_price_seven  <= i_cfg_wdata;
                REG_PRICE_THIRTY: r_price_thirty <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_day   <= i_travel_day;
            r_first <= i_first;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_proc) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_cost <= n_cost;
            r_out_err  <= n_err;
        end
    end

    // History control state. A rejected day leaves everything untouched;
    // a start flag on an accepted day clears first, then pushes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_vld <= '0;
            r_evicted <= '0;
            r_running <= '0;
        end else if (w_proc && !w_err) begin
            r_win_vld <= {w_vld_eff[WINDOW_DEPTH-2:0], 1'b1};
            r_evicted <= w_vld_eff[WINDOW_DEPTH-1] ? r_win_cost[WINDOW_DEPTH-1]
                                                   : w_evicted_eff;
            r_running <= n_cost;
        end
    end

    // History payload shifts with the valid bits.
    always_ff @(posedge i_clk) begin
        if (w_proc && !w_err) begin
            for (int k = WINDOW_DEPTH - 1; k > 0; k--) begin
                r_win_day[k]  <= r_win_day[k-1];
                r_win_cost[k] <= r_win_cost[k-1];
            end
            r_win_day[0]  <= r_day;
            r_win_cost[0] <= n_cost;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_total_cost  = r_out_cost;
    assign o_order_error = r_out_err;

endmodule

// ===== rtl/mcpc_lookup.sv =====
`timescale 1ns / 1ps

module mcpc_lookup #(
    parameter int DEPTH = 30
) (
    input  mcpc_pkg::t_day   i_win_day  [DEPTH],
    input  mcpc_pkg::t_cost  i_win_cost [DEPTH],
    input  logic [DEPTH-1:0] i_win_vld,
    input  mcpc_pkg::t_limit i_limit,
    input  mcpc_pkg::t_cost  i_fallback,
    output mcpc_pkg::t_cost  o_cost
);
    import mcpc_pkg::*;

    // Cost of the newest kept day at or below the limit. All entries are
    // compared at once; the lowest index (newest day) wins.
    always_comb begin
        o_cost = i_fallback;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (i_win_vld[k] && ($signed({2'b00, i_win_day[k]}) <= i_limit)) begin
                o_cost = i_win_cost[k];
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the travel pass cost block. A directed table runs
// first at the reset prices, then six random phases each program new prices
// and use one of several patterns of sender gaps and receiver stalls. Every
// accepted item is run through a local model of the forward cost recursion.
// Every accepted result is compared against the oldest pending prediction.

module tb_top;

    import mcpc_pkg::*;

    localparam int HIST_DEPTH     = 30;
    localparam int PHASE_ITEMS    = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int DIR_N          = 20;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle;

    // One predicted result item.
    typedef struct packed {
        t_cost cost;
        logic  err;
    } t_quote;

    // One row of the directed table. When has_exp is set the typed cost and
    // error flag are checked in place of the model's prediction.
    typedef struct packed {
        t_day  day;
        logic  first;
        logic  has_exp;
        t_cost cost;
        logic  err;
    } t_row;

    // The directed rows run at the reset prices (2, 7, 15), so a plan that
    // has just started always costs exactly one one-day pass.
    localparam t_row DIR_ROWS [DIR_N] = '{
        // Empty history after reset: the day is taken as the start of a plan.
        '{9'd5,   1'b0, 1'b1, 19'd2, 1'b0},
        // Same day again, then an earlier day: both are out of order.
        '{9'd5,   1'b0, 1'b1, 19'd2, 1'b1},
        '{9'd3,   1'b0, 1'b1, 19'd2, 1'b1},
        // A short run of consecutive days so the seven-day pass takes over.
        '{9'd6,   1'b0, 1'b0, 19'd0, 1'b0},
        '{9'd7,   1'b0, 1'b0, 19'd0, 1'b0},
        '{9'd8,   1'b0, 1'b0, 19'd0, 1'b0},
        '{9'd9,   1'b0, 1'b0, 19'd0, 1'b0},
        // Start flag on day zero, then day zero again without the flag.
        '{9'd0,   1'b1, 1'b1, 19'd2, 1'b0},
        '{9'd0,   1'b0, 1'b1, 19'd2, 1'b1},
        '{9'd1,   1'b0, 1'b0, 19'd0, 1'b0},
        // Jump to the largest day, repeat it, then fall back to zero.
        '{9'd511, 1'b0, 1'b0, 19'd0, 1'b0},
        '{9'd511, 1'b0, 1'b0, 19'd0, 1'b0},
        '{9'd0,   1'b0, 1'b0, 19'd0, 1'b0},
        // A restart is never checked for order, even going downward.
        '{9'd511, 1'b1, 1'b1, 19'd2, 1'b0},
        '{9'd1,   1'b1, 1'b1, 19'd2, 1'b0},
        '{9'd365, 1'b0, 1'b0, 19'd0, 1'b0},
        '{9'd366, 1'b0, 1'b0, 19'd0, 1'b0},
        '{9'd255, 1'b1, 1'b1, 19'd2, 1'b0},
        '{9'd256, 1'b0, 1'b0, 19'd0, 1'b0},
        '{9'd286, 1'b0, 1'b0, 19'd0, 1'b0}
    };

    // Every input is driven to a known value from time zero.
    logic   i_clk         = 1'b0;
    logic   i_rst_n       = 1'b0;
    logic   i_cfg_wr_en   = 1'b0;
    logic   [1:0] i_cfg_addr = REG_PRICE_ONE;
    t_price i_cfg_wdata   = '0;
    logic   i_in_valid    = 1'b0;
    t_day   i_travel_day  = '0;
    logic   i_first       = 1'b0;
    logic   i_out_ready   = 1'b0;
    logic   o_in_ready;
    logic   o_out_valid;
    t_cost  o_total_cost;
    logic   o_order_error;

    min_cost_pass_cover u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_travel_day  (i_travel_day),
        .i_first       (i_first),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_total_cost  (o_total_cost),
        .o_order_error (o_order_error)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Local copy of the block's state and prices for cost prediction.
    t_price price_one    = t_price'(2);
    t_price price_seven  = t_price'(7);
    t_price price_thirty = t_price'(15);
    t_day   hist_day  [HIST_DEPTH];
    t_cost  hist_cost [HIST_DEPTH];
    bit     hist_vld  [HIST_DEPTH];
    t_cost  evicted_total = '0;
    t_cost  plan_total    = '0;

    t_quote quote_q [$];

    // Side information for the item currently offered on the input channel.
    logic   row_has_exp = 1'b0;
    t_cost  row_cost    = '0;
    logic   row_err     = 1'b0;

    // Order tracking as seen by the stimulus generator.
    bit     gen_have_hist = 1'b0;
    int     gen_last_day  = 0;

    t_idle  mode        = IDLE_NONE;
    int     idle_pct    = 0;
    int     stall_run   = 0;
    int     stuck_cycles = 0;
    int     fail_count  = 0;

    // Advance the local model by one accepted item and return its result.
    // best(t) is the cost of the newest kept day at or below t, falling back
    // to the cost of the last day pushed out of the window.
    function automatic t_quote plan_step(t_day day, logic first);
        t_quote      res;
        t_cost       best;
        t_cost       prior;
        int unsigned sum;
        int          lim;
        bit          found;
        int          lens [3];
        t_price      prices [3];
        lens   = '{int'(PASS_ONE), int'(PASS_SEVEN), int'(PASS_THIRTY)};
        prices = '{price_one, price_seven, price_thirty};
        if (first) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                hist_day[k]  = '0;
                hist_cost[k] = '0;
                hist_vld[k]  = 1'b0;
            end
            evicted_total = '0;
            plan_total    = '0;
        end
        if (hist_vld[0] && day <= hist_day[0]) begin
            res.cost = plan_total;
            res.err  = 1'b1;
            return res;
        end
        best = COST_MAX;
        for (int j = 0; j < 3; j++) begin
            lim   = int'(day) - lens[j];
            prior = evicted_total;
            found = 1'b0;
            for (int k = 0; k < HIST_DEPTH; k++) begin
                if (!found && hist_vld[k] && int'(hist_day[k]) <= lim) begin
                    prior = hist_cost[k];
                    found = 1'b1;
                end
            end
            sum = int'(prices[j]) + int'(prior);
            if (sum > int'(COST_MAX)) begin
                sum = int'(COST_MAX);
            end
            if (t_cost'(sum) < best) begin
                best = t_cost'(sum);
            end
        end
        if (hist_vld[HIST_DEPTH-1]) begin
            evicted_total = hist_cost[HIST_DEPTH-1];
        end
        for (int k = HIST_DEPTH - 1; k > 0; k--) begin
            hist_day[k]  = hist_day[k-1];
            hist_cost[k] = hist_cost[k-1];
            hist_vld[k]  = hist_vld[k-1];
        end
        hist_day[0]  = day;
        hist_cost[0] = best;
        hist_vld[0]  = 1'b1;
        plan_total   = best;
        res.cost = best;
        res.err  = 1'b0;
        return res;
    endfunction

    // Receiver: in the stalling modes ready drops at random, but each stall run
    // is capped by the stall_run limit, which keeps the watchdog bound sound.
    always @(negedge i_clk) begin
        if ((mode == IDLE_RECV || mode == IDLE_BOTH) && stall_run < 12
                && $urandom_range(0, 99) < idle_pct) begin
            i_out_ready <= 1'b0;
            stall_run   <= stall_run + 1;
        end else begin
            i_out_ready <= 1'b1;
            stall_run   <= 0;
        end
    end

    // Monitor: inputs are handled before outputs so that a prediction is
    // always queued before the matching result could be taken.
    always @(posedge i_clk) begin
        t_quote want;
        bit     moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                want = plan_step(i_travel_day, i_first);
                if (row_has_exp) begin
                    want.cost = row_cost;
                    want.err  = row_err;
                end
                quote_q.insert(quote_q.size(), want);
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (quote_q.size() == 0) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("%0t: unexpected result cost=%0d err=%0b",
                                 $realtime, o_total_cost, o_order_error);
                    end
                    fail_count++;
                end else begin
                    want = quote_q.pop_front();
                    if (o_total_cost !== want.cost || o_order_error !== want.err) begin
                        if (fail_count < MAX_REPORTS) begin
                            $display("%0t: mismatch cost exp=%0d got=%0d err exp=%0b got=%0b",
                                     $realtime, want.cost, o_total_cost,
                                     want.err, o_order_error);
                        end
                        fail_count++;
                    end
                end
            end
            stuck_cycles <= moved ? 0 : stuck_cycles + 1;
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    initial begin
        while (stuck_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("FAILURE");
        $finish;
    end

    // Write one price register and mirror it into the model. Only called
    // while nothing is in flight.
    task automatic write_price(logic [1:0] addr, int value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= t_price'(value);
        case (addr)
            REG_PRICE_ONE:    price_one    = t_price'(value);
            REG_PRICE_SEVEN:  price_seven  = t_price'(value);
            REG_PRICE_THIRTY: price_thirty = t_price'(value);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Offer one item and wait for it to be accepted. A gap or a full drain
    // of pending results may come first, with valid held low meanwhile.
    // In the sender idling modes each cycle is idle with the phase's odds.
    // taken reports whether the block will use the day rather than flag it.
    task automatic send_item(t_day day, logic first, logic has_exp, t_cost cost,
                             logic err, bit pause, output bit taken);
        int gap;
        gap = 0;
        if (mode == IDLE_SEND || mode == IDLE_BOTH) begin
            while (gap < 64 && $urandom_range(0, 99) < idle_pct) begin
                gap++;
            end
        end
        if (pause && gap == 0) begin
            gap = 1;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            if (pause) begin
                while (quote_q.size() != 0) begin
                    @(negedge i_clk);
                end
            end
        end
        row_has_exp = has_exp;
        row_cost    = cost;
        row_err     = err;
        i_in_valid   <= 1'b1;
        i_travel_day <= day;
        i_first      <= first;
        taken = first || !gen_have_hist || int'(day) > gen_last_day;
        if (taken) begin
            gen_have_hist = 1'b1;
            gen_last_day  = int'(day);
        end
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
    endtask

    // Lower valid and wait until every predicted result has come back, then let
    // the two-stage pipeline settle.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (quote_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        bit   taken;
        int   kept;
        int   r;
        int   gap;
        int   next_day;
        t_day day;
        logic first;
        bit   pause;

        for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_day[k]  = '0;
            hist_cost[k] = '0;
            hist_vld[k]  = 1'b0;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at the reset prices, no idling on either side.
        for (int i = 0; i < DIR_N; i++) begin
            send_item(DIR_ROWS[i].day, DIR_ROWS[i].first, DIR_ROWS[i].has_exp,
                      DIR_ROWS[i].cost, DIR_ROWS[i].err, 1'b0, taken);
        end
        drain_results();

        // Random phases. Each one reprograms all three prices and sets the idling
        // pattern anew; the plan history carries over between phases.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    write_price(REG_PRICE_ONE, 1);
                    write_price(REG_PRICE_SEVEN, 1);
                    write_price(REG_PRICE_THIRTY, 1);
                    mode = IDLE_NONE;
                    idle_pct = 0;
                end
                1: begin
                    write_price(REG_PRICE_ONE, 1023);
                    write_price(REG_PRICE_SEVEN, 1023);
                    write_price(REG_PRICE_THIRTY, 1023);
                    mode = IDLE_SEND;
                    idle_pct = 69;
                end
                2: begin
                    write_price(REG_PRICE_ONE, 0);
                    write_price(REG_PRICE_SEVEN, 0);
                    write_price(REG_PRICE_THIRTY, 0);
                    mode = IDLE_RECV;
                    idle_pct = 69;
                end
                3: begin
                    write_price(REG_PRICE_ONE, 1000);
                    write_price(REG_PRICE_SEVEN, 1);
                    write_price(REG_PRICE_THIRTY, 1000);
                    mode = IDLE_BOTH;
                    idle_pct = 27;
                end
                4: begin
                    write_price(REG_PRICE_ONE, $urandom_range(1, 1000));
                    write_price(REG_PRICE_SEVEN, $urandom_range(1, 1000));
                    write_price(REG_PRICE_THIRTY, $urandom_range(1, 1000));
                    mode = IDLE_NONE;
                    idle_pct = 0;
                end
                default: begin
                    write_price(REG_PRICE_ONE, $urandom_range(0, 1023));
                    write_price(REG_PRICE_SEVEN, $urandom_range(0, 1023));
                    write_price(REG_PRICE_THIRTY, $urandom_range(0, 1023));
                    mode = IDLE_BOTH;
                    idle_pct = 27;
                end
            endcase

            // Mostly well-formed plans: a start day followed by rising days,
            // with short gaps dominating so the window fills and evicts.
            // A few items are out-of-order noise or unexpected restarts.
            kept = 0;
            while (kept < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                first = 1'b0;
                if (!gen_have_hist || r < 4) begin
                    first = 1'b1;
                    day = ($urandom_range(0, 99) < 85) ? t_day'($urandom_range(0, 40))
                                                       : t_day'($urandom_range(0, 511));
                end else if (r < 10) begin
                    day = t_day'($urandom_range(0, gen_last_day));
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 50) begin
                        gap = 1;
                    end else if (r < 80) begin
                        gap = $urandom_range(2, 5);
                    end else if (r < 95) begin
                        gap = $urandom_range(6, 31);
                    end else begin
                        gap = $urandom_range(32, 80);
                    end
                    next_day = gen_last_day + gap;
                    if (next_day > 511) begin
                        first = 1'b1;
                        day = t_day'($urandom_range(0, 40));
                    end else begin
                        day = t_day'(next_day);
                    end
                end
                // Now and then the sender holds off until the block is empty.
                pause = (kept == 40) || ($urandom_range(0, 63) == 0);
                send_item(day, first, 1'b0, '0, 1'b0, pause, taken);
                if (taken) begin
                    kept++;
                end
            end
            drain_results();
        end

        if (fail_count == 0 && quote_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
